FILE: rtl/core/pnc_pkg.sv
// shared types and constants for the nearest palette color search block
// no dependencies
package pnc_pkg;

  localparam int unsigned IDX_W   = 8;
  localparam int unsigned COMP_W  = 8;
  localparam int unsigned DIST_W  = 18;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned COLOR_W = 15;
  localparam int unsigned CQ_W    = 5;
  localparam int unsigned N_COMP  = 3;

  localparam logic [COMP_W-1:0] ALPHA_OPAQUE = 8'hFF;
  localparam logic [COMP_W-1:0] ALPHA_CLEAR  = 8'h00;

  typedef enum logic [1:0] {
    ACT_WRITE  = 2'd0,
    ACT_LOOKUP = 2'd1,
    ACT_QUERY  = 2'd2,
    ACT_SKIP   = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [COMP_W-1:0] b;
    logic [COMP_W-1:0] g;
    logic [COMP_W-1:0] r;
  } rgb_t;

  typedef struct packed {
    logic              vld;
    rgb_t              entry;
    logic [DIST_W-1:0] sum;
  } cell_beat_t;

  // 5-bit query component to 8 bits: c*8+4
  function automatic logic [COMP_W-1:0] widen(input logic [CQ_W-1:0] c);
    widen = {c, 3'b100};
  endfunction

endpackage

FILE: rtl/core/pnc_ram.sv
// generic single write port ram with registered read
// no dependencies
module pnc_ram #(
  parameter int unsigned Width = 24,
  parameter int unsigned Depth = 256,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/pnc_cell.sv
// distance cell: adds the squared difference of one color component to the beat
// depends on pnc_pkg
module pnc_cell import pnc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  logic [COMP_W-1:0] q_comp_i,
  input  logic [COMP_W-1:0] comp_i,
  input  cell_beat_t        beat_i,
  output cell_beat_t        beat_o
);

  logic [COMP_W-1:0]   q_q;
  logic                vld_q;
  rgb_t                entry_q;
  logic [DIST_W-1:0]   sum_q, sum_d;
  logic [COMP_W-1:0]   diff;
  logic [2*COMP_W-1:0] sq;

  always_comb begin
    diff  = (q_q >= comp_i) ? (q_q - comp_i) : (comp_i - q_q);
    sq    = diff * diff;
    sum_d = beat_i.sum + DIST_W'(sq);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= beat_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      q_q <= q_comp_i;
    end
    entry_q <= beat_i.entry;
    sum_q   <= sum_d;
  end

  assign beat_o = '{vld: vld_q, entry: entry_q, sum: sum_q};

endmodule

FILE: rtl/core/nearest_palette_color_search.sv
// top level of the nearest palette color search block
// depends on pnc_pkg, pnc_ram, pnc_cell
//
// usage:
//   input channel (in_valid_i/in_ready_o) takes one beat per item: a write
//   stores red/green/blue at entry_index, a lookup returns the packed ABGR
//   word of an entry, a query returns the nearest entry to color15 and its
//   squared distance. action 3 is taken and dropped.
//   output channel (out_valid_o/out_ready_i) carries one beat per lookup
//   or query; writes give no beat.
//   in_ready_o stays high after a write. a lookup reads the ram into the
//   result register, then moves it to the output register; the next item
//   is taken after that move. a query streams every palette entry out of
//   the ram one per cycle through three distance cells and a minimum
//   stage, with the ram read port setting the rate of one entry per cycle.
//   in_ready_o is high only while no item is in flight; a finished result
//   sits in the output register, so the next item may be taken while the
//   receiver stalls. a further result then waits until that beat is taken.
//   reset empties the control path; palette contents are undefined until
//   written, and every entry must be written before a query.
module nearest_palette_color_search import pnc_pkg::*; #(
  parameter int unsigned PALETTE_SIZE = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         action_i,
  input  logic [IDX_W-1:0]   entry_index_i,
  input  logic [COMP_W-1:0]  red_i,
  input  logic [COMP_W-1:0]  green_i,
  input  logic [COMP_W-1:0]  blue_i,
  input  logic [COLOR_W-1:0] color15_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [IDX_W-1:0]   nearest_index_o,
  output logic [DIST_W-1:0]  distance_o,
  output logic [WORD_W-1:0]  packed_word_o
);

  localparam int unsigned AW = $clog2(PALETTE_SIZE);
  localparam logic [IDX_W:0]   PAL_SIZE_EXT = (IDX_W+1)'(PALETTE_SIZE);
  localparam logic [AW-1:0]    LAST_ADDR    = AW'(PALETTE_SIZE - 1);
  localparam logic [IDX_W-1:0] LAST_IDX     = IDX_W'(PALETTE_SIZE - 1);

  state_e state_q, state_d;

  logic           accept;
  logic           in_range;
  logic           ram_we;
  logic [AW-1:0]  ram_raddr;
  rgb_t           ram_wdata, ram_rdata;
  logic           out_load;
  logic           query_start;
  logic           lookup_start;
  logic           issue;

  logic [AW-1:0]  scan_q;
  logic           rd_vld_q;
  logic           lk_range_q, lk_last_q;

  cell_beat_t     beats [N_COMP+1];
  logic [COMP_W-1:0] q_comp [N_COMP];

  logic [AW-1:0]  min_cnt_q;
  logic           min_take;
  logic           done_q;

  logic [IDX_W-1:0]  res_idx_q;
  logic [DIST_W-1:0] res_dist_q;
  logic [WORD_W-1:0] res_word_q;

  logic              out_valid_q;
  logic [IDX_W-1:0]  out_idx_q;
  logic [DIST_W-1:0] out_dist_q;
  logic [WORD_W-1:0] out_word_q;

  // fsm next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (action_i)
            ACT_LOOKUP: state_d = ST_LOOKUP;
            ACT_QUERY:  state_d = ST_SCAN;
            default:    state_d = ST_IDLE;
          endcase
        end
      end
      ST_LOOKUP: state_d = ST_DONE;
      ST_SCAN: begin
        if (scan_q == LAST_ADDR) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (done_q) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // fsm outputs
  always_comb begin
    in_ready_o   = (state_q == ST_IDLE);
    accept       = in_valid_i && in_ready_o;
    in_range     = {1'b0, entry_index_i} < PAL_SIZE_EXT;
    ram_we       = accept && (action_i == ACT_WRITE) && in_range;
    lookup_start = accept && (action_i == ACT_LOOKUP);
    query_start  = accept && (action_i == ACT_QUERY);
    issue        = (state_q == ST_SCAN);
    ram_raddr    = issue ? scan_q : entry_index_i[AW-1:0];
    out_load     = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      scan_q      <= '0;
      rd_vld_q    <= 1'b0;
      done_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= issue;
      done_q   <= min_take && (min_cnt_q == LAST_ADDR);
      if (query_start) begin
        scan_q <= '0;
      end else if (issue) begin
        scan_q <= scan_q + AW'(1);
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign ram_wdata = '{b: blue_i, g: green_i, r: red_i};

  pnc_ram #(
    .Width ($bits(rgb_t)),
    .Depth (PALETTE_SIZE)
  ) u_palette (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (entry_index_i[AW-1:0]),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // distance cells, one per color component
  assign beats[0] = '{vld: rd_vld_q, entry: ram_rdata, sum: '0};

  for (genvar k = 0; k < N_COMP; k++) begin : g_cell
    logic [COMP_W-1:0] comp;

    assign q_comp[k] = widen(color15_i[CQ_W*k +: CQ_W]);
    assign comp = (k == 0) ? beats[k].entry.r :
                  (k == 1) ? beats[k].entry.g : beats[k].entry.b;

    pnc_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .load_i   (query_start),
      .q_comp_i (q_comp[k]),
      .comp_i   (comp),
      .beat_i   (beats[k]),
      .beat_o   (beats[k+1])
    );
  end

  // running minimum, lower index wins ties
  assign min_take = beats[N_COMP].vld;

  always_ff @(posedge clk_i) begin
    if (lookup_start) begin
      lk_range_q <= in_range;
      lk_last_q  <= (entry_index_i == LAST_IDX);
    end
    if (query_start) begin
      min_cnt_q  <= '0;
      res_word_q <= '0;
    end else if (min_take) begin
      min_cnt_q <= min_cnt_q + AW'(1);
      if ((min_cnt_q == '0) || (beats[N_COMP].sum < res_dist_q)) begin
        res_idx_q  <= IDX_W'(min_cnt_q);
        res_dist_q <= beats[N_COMP].sum;
      end
    end else if (state_q == ST_LOOKUP) begin
      res_idx_q  <= '0;
      res_dist_q <= '0;
      res_word_q <= lk_range_q ? {(lk_last_q ? ALPHA_CLEAR : ALPHA_OPAQUE), ram_rdata} : '0;
    end
    if (out_load) begin
      out_idx_q  <= res_idx_q;
      out_dist_q <= res_dist_q;
      out_word_q <= res_word_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign nearest_index_o = out_idx_q;
  assign distance_o      = out_dist_q;
  assign packed_word_o   = out_word_q;

endmodule

FILE: rtl/core/pnc_checker.sv
// port-level checks for the nearest palette color search block
// depends on pnc_pkg; bound to nearest_palette_color_search
module pnc_checker import pnc_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic [1:0]         action_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [IDX_W-1:0]   nearest_index_o,
  input logic [DIST_W-1:0]  distance_o,
  input logic [WORD_W-1:0]  packed_word_o
);

  // a result beat held back stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(packed_word_o)
      && $stable(nearest_index_o) && $stable(distance_o))
    else $error("stalled result beat changed");

  // a lookup or query occupies the block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (action_i == ACT_LOOKUP || action_i == ACT_QUERY)
      |=> !in_ready_o)
    else $error("input taken while a lookup or query is in flight");

  // writes and unused actions leave the block free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (action_i == ACT_WRITE || action_i == ACT_SKIP)
      |=> in_ready_o)
    else $error("write stalled the input");

  // a result is either a packed word or an index/distance pair
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (packed_word_o == '0) || (nearest_index_o == '0 && distance_o == '0))
    else $error("result mixes lookup and query fields");

  // a query scans the whole palette, so no result the cycle after it is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && action_i == ACT_QUERY && !out_valid_o
      |=> !out_valid_o)
    else $error("query result too early");

endmodule

bind nearest_palette_color_search pnc_checker u_pnc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_ready_o      (in_ready_o),
  .action_i        (action_i),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .nearest_index_o (nearest_index_o),
  .distance_o      (distance_o),
  .packed_word_o   (packed_word_o)
);
